/* design/ppp_pkg.sv */
// Shared types and constants of the perspective point projector.
`default_nettype none
package ppp_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int DIM_WIDTH = 13;
  localparam int NEAR_WIDTH = 31;
  localparam int INDEX_WIDTH = 4;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int MATRIX_WORDS = 16;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_PROJECT = 1'b1;

  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SCREEN_WIDTH = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NEAR_W_LIMIT = 2'd2;

  localparam logic [DIM_WIDTH-1:0] RESET_SCREEN_WIDTH = 13'd1280;
  localparam logic [DIM_WIDTH-1:0] RESET_SCREEN_HEIGHT = 13'd1024;
  localparam logic [NEAR_WIDTH-1:0] RESET_NEAR_W_LIMIT = 31'd6554;

  typedef struct packed {
    logic                          kind;
    logic [INDEX_WIDTH-1:0]        matrix_index;
    logic signed [COORD_WIDTH-1:0] matrix_value;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] screen_x;
    logic signed [COORD_WIDTH-1:0] screen_y;
    logic                          visible;
  } out_item_t;

  typedef struct packed {
    logic                          visible;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic signed [COORD_WIDTH-1:0] cw;
  } clip_res_t;

  typedef struct packed {
    logic [DIM_WIDTH-1:0]  screen_width;
    logic [DIM_WIDTH-1:0]  screen_height;
    logic [NEAR_WIDTH-1:0] near_w_limit;
  } cfg_t;

endpackage
`default_nettype wire

/* design/ppp_front.sv */
// Input side: two-entry queue that takes item transfers.
`default_nettype none
module ppp_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire ppp_pkg::in_item_t in_data,
  output logic                   q_valid,
  input  wire logic              q_pop,
  output ppp_pkg::in_item_t      q_data
);

  ppp_pkg::in_item_t slot [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  logic       push;

  assign in_stall = (count == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (count != 2'd0);
  assign q_data = slot[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule
`default_nettype wire

/* design/ppp_clip.sv */
// Matrix store and clip-space transform with near test.
`default_nettype none
module ppp_clip #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           adv,
  input  wire logic                           q_valid,
  input  wire ppp_pkg::in_item_t              q_data,
  input  wire logic [ppp_pkg::NEAR_WIDTH-1:0] near_w_limit,
  output logic                                pop,
  output logic                                res_valid,
  output ppp_pkg::clip_res_t                  res
);

  localparam int CW = ppp_pkg::COORD_WIDTH;
  localparam int SW = 2 * CW + 2;
  localparam logic signed [SW-1:0] CLIP_MAX = (SW'(1) << (CW - 1)) - SW'(1);
  localparam logic signed [SW-1:0] CLIP_MIN = ~CLIP_MAX;

  logic signed [CW-1:0] mtx [ppp_pkg::MATRIX_WORDS];
  logic signed [CW-1:0] pos [3];
  logic signed [2*CW-1:0] prd [3][3];
  logic signed [CW-1:0] ofs [3];
  logic signed [SW-1:0] sum [3];
  logic signed [CW-1:0] clip [3];
  logic v1;
  logic v2;
  logic v3;
  logic vis;

  assign pop = adv && q_valid;
  assign pos[0] = q_data.pos_x;
  assign pos[1] = q_data.pos_y;
  assign pos[2] = q_data.pos_z;

  always_ff @(posedge clk) begin
    if (pop && q_data.kind == ppp_pkg::KIND_LOAD) begin
      mtx[q_data.matrix_index] <= q_data.matrix_value;
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_row
    localparam int ROW = (l == 2) ? 3 : l;
    logic signed [SW-1:0] sh;

    for (genvar k = 0; k < 3; k++) begin : g_term
      always_ff @(posedge clk) begin
        if (adv) prd[l][k] <= pos[k] * mtx[ROW + 4 * k];
      end
    end

    assign sh = sum[l] >>> FRAC_BITS;

    always_ff @(posedge clk) begin
      if (adv) begin
        ofs[l] <= mtx[ROW + 12];
        sum[l] <= SW'(prd[l][0]) + SW'(prd[l][1]) + SW'(prd[l][2])
                  + (SW'(ofs[l]) <<< FRAC_BITS);
        if (sh > CLIP_MAX) clip[l] <= CLIP_MAX[CW-1:0];
        else if (sh < CLIP_MIN) clip[l] <= CLIP_MIN[CW-1:0];
        else clip[l] <= sh[CW-1:0];
      end
    end
  end

  // w must be positive and reach the near limit
  assign vis = !clip[2][CW-1] && (|clip[2])
               && ($signed({clip[2][CW-1], clip[2]})
                   >= $signed({{(CW + 1 - ppp_pkg::NEAR_WIDTH){1'b0}}, near_w_limit}));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= q_valid && q_data.kind == ppp_pkg::KIND_PROJECT;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign res_valid = v3;
  assign res.visible = vis;
  assign res.cx = clip[0];
  assign res.cy = clip[1];
  assign res.cw = clip[2];

endmodule
`default_nettype wire

/* design/ppp_divider.sv */
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
`default_nettype none
module ppp_divider #(
  parameter int DW = 32,
  parameter int TW = 61,
  parameter int QB = 33
) (
  input  wire logic          clk,
  input  wire logic          adv,
  input  wire logic [TW-1:0] t,
  input  wire logic [DW-1:0] d,
  output logic [QB-1:0]      q,
  output logic               ovf
);

  logic [DW-1:0] rem [QB];
  logic [DW-1:0] dv [QB];
  logic [QB-1:0] low [QB];
  logic [QB-1:0] quo [QB+1];
  logic          ovf_s [QB+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      ovf_s[0] <= (t >> QB) >= TW'(d);
      rem[0] <= DW'(t >> QB);
      low[0] <= t[QB-1:0];
      dv[0] <= d;
      quo[0] <= '0;
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_stage
    logic [DW:0] trial;
    logic        ge;

    assign trial = {rem[i-1], low[i-1][QB-1]};
    assign ge = trial >= {1'b0, dv[i-1]};

    always_ff @(posedge clk) begin
      if (adv) begin
        quo[i] <= {quo[i-1][QB-2:0], ge};
        ovf_s[i] <= ovf_s[i-1];
      end
    end

    if (i < QB) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          rem[i] <= ge ? DW'(trial - {1'b0, dv[i-1]}) : trial[DW-1:0];
          low[i] <= low[i-1] << 1;
          dv[i] <= dv[i-1];
        end
      end
    end
  end

  assign q = quo[QB];
  assign ovf = ovf_s[QB];

endmodule
`default_nettype wire

/* design/ppp_screen.sv */
// Viewport mapping: scale, divide by 2w, offset, saturate, output register.
`default_nettype none
module ppp_screen #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  wire logic                          res_valid,
  input  wire ppp_pkg::clip_res_t            res,
  input  wire logic [ppp_pkg::DIM_WIDTH-1:0] screen_width,
  input  wire logic [ppp_pkg::DIM_WIDTH-1:0] screen_height,
  output logic                               out_valid,
  output ppp_pkg::out_item_t                 out_data
);

  localparam int CW = ppp_pkg::COORD_WIDTH;
  localparam int DMW = ppp_pkg::DIM_WIDTH;
  localparam int PW = CW + DMW;
  localparam int TW = PW + FRAC_BITS;
  localparam int HW = DMW + FRAC_BITS - 1;
  localparam int QB = ((CW > HW + 1) ? CW : HW + 1) + 1;
  localparam int LAT = QB + 1;
  localparam int SUMW = QB + 2;
  localparam logic signed [SUMW-1:0] OUT_MAX = (SUMW'(1) << (CW - 1)) - SUMW'(1);
  localparam logic signed [SUMW-1:0] OUT_MIN = ~OUT_MAX;

  logic          v4;
  logic          vis4;
  logic          neg4 [2];
  logic [CW-1:0] mag4 [2];
  logic [CW-1:0] d4;
  logic          v5;
  logic          vis5;
  logic          neg5 [2];
  logic [PW-1:0] prd5 [2];
  logic [CW-1:0] d5;
  logic          vd [LAT];
  logic          visd [LAT];
  logic          negd [2][LAT];
  logic [QB-1:0] q [2];
  logic          ovf [2];
  logic [HW-1:0] half [2];
  logic [DMW-1:0] dim [2];
  logic signed [CW-1:0] cc [2];
  logic signed [CW-1:0] lane_out [2];
  logic          v_out;

  assign dim[0] = screen_width;
  assign dim[1] = screen_height;
  assign cc[0] = res.cx;
  assign cc[1] = res.cy;

  always_ff @(posedge clk) begin
    if (adv) begin
      vis4 <= res.visible;
      d4 <= {res.cw[CW-2:0], 1'b0};
      vis5 <= vis4;
      d5 <= d4;
      visd[0] <= vis5;
      for (int i = 1; i < LAT; i++) visd[i] <= visd[i-1];
    end
  end

  for (genvar l = 0; l < 2; l++) begin : g_lane
    logic signed [SUMW-1:0] qs;
    logic signed [SUMW-1:0] s;

    always_ff @(posedge clk) begin
      if (adv) begin
        // y runs against the screen axis, so its term is negated
        neg4[l] <= (l == 0) ? cc[l][CW-1] : !cc[l][CW-1];
        mag4[l] <= cc[l][CW-1] ? CW'(-cc[l]) : CW'(cc[l]);
        neg5[l] <= neg4[l];
        prd5[l] <= PW'(mag4[l]) * PW'(dim[l]);
        negd[l][0] <= neg5[l];
        for (int i = 1; i < LAT; i++) negd[l][i] <= negd[l][i-1];
      end
    end

    ppp_divider #(
      .DW(CW),
      .TW(TW),
      .QB(QB)
    ) u_div (
      .clk(clk),
      .adv(adv),
      .t({prd5[l], {FRAC_BITS{1'b0}}}),
      .d(d5),
      .q(q[l]),
      .ovf(ovf[l])
    );

    assign half[l] = HW'(dim[l]) << (FRAC_BITS - 1);
    assign qs = negd[l][LAT-1] ? -$signed({2'b00, q[l]}) : $signed({2'b00, q[l]});
    assign s = qs + $signed(SUMW'(half[l]));

    always_comb begin
      if (!visd[LAT-1]) lane_out[l] = '0;
      else if (ovf[l]) lane_out[l] = negd[l][LAT-1] ? OUT_MIN[CW-1:0] : OUT_MAX[CW-1:0];
      else if (s > OUT_MAX) lane_out[l] = OUT_MAX[CW-1:0];
      else if (s < OUT_MIN) lane_out[l] = OUT_MIN[CW-1:0];
      else lane_out[l] = s[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.screen_x <= lane_out[0];
      out_data.screen_y <= lane_out[1];
      out_data.visible <= visd[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      for (int i = 0; i < LAT; i++) vd[i] <= 1'b0;
      v_out <= 1'b0;
    end else if (adv) begin
      v4 <= res_valid;
      v5 <= v4;
      vd[0] <= v5;
      for (int i = 1; i < LAT; i++) vd[i] <= vd[i-1];
      v_out <= vd[LAT-1];
    end
  end

  assign out_valid = v_out;

endmodule
`default_nettype wire

/* design/perspective_point_projector.sv */
// Top level of the perspective point projector.
// Takes one item transfer per cycle, sustained while the output is not stalled. A load
// writes one matrix word and gives no result; a project's result is carried through the
// queue slot, three clip stages, two scaling stages, an input stage and one stage per
// quotient bit in each divider lane, then the output register.
// The rate is set by the fully pipelined clip multipliers and the bit-per-stage divider
// lanes; every item, loads included, takes one pipeline slot. A stalled output
// freezes the back pipeline and the two-entry input queue keeps taking transfers
// until it is full. Configuration writes are always ready and are meant for idle time.
`default_nettype none
module perspective_point_projector #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire ppp_pkg::in_item_t                   in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output ppp_pkg::out_item_t                       out_data,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ppp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [ppp_pkg::NEAR_WIDTH-1:0]      cfg_data
);

  ppp_pkg::cfg_t      cfg;
  ppp_pkg::in_item_t  q_data;
  ppp_pkg::clip_res_t res;
  logic q_valid;
  logic pop;
  logic res_valid;
  logic adv;

  assign cfg_ready = 1'b1;
  assign adv = !(out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width <= ppp_pkg::RESET_SCREEN_WIDTH;
      cfg.screen_height <= ppp_pkg::RESET_SCREEN_HEIGHT;
      cfg.near_w_limit <= ppp_pkg::RESET_NEAR_W_LIMIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ppp_pkg::CFG_SCREEN_WIDTH: cfg.screen_width <= cfg_data[ppp_pkg::DIM_WIDTH-1:0];
        ppp_pkg::CFG_SCREEN_HEIGHT: cfg.screen_height <= cfg_data[ppp_pkg::DIM_WIDTH-1:0];
        ppp_pkg::CFG_NEAR_W_LIMIT: cfg.near_w_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  ppp_front u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .q_valid(q_valid),
    .q_pop(pop),
    .q_data(q_data)
  );

  ppp_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .q_valid(q_valid),
    .q_data(q_data),
    .near_w_limit(cfg.near_w_limit),
    .pop(pop),
    .res_valid(res_valid),
    .res(res)
  );

  ppp_screen #(.FRAC_BITS(FRAC_BITS)) u_screen (
    .clk(clk),
    .rst(rst),
    .adv(adv),
    .res_valid(res_valid),
    .res(res),
    .screen_width(cfg.screen_width),
    .screen_height(cfg.screen_height),
    .out_valid(out_valid),
    .out_data(out_data)
  );

endmodule
`default_nettype wire

/* design/ppp_checker.sv */
// Port-level assertions for the projector and their bind.
`default_nettype none
module ppp_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire ppp_pkg::out_item_t out_data,
  input wire logic               cfg_valid,
  input wire logic               cfg_ready
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.visible |-> out_data.screen_x == 0 && out_data.screen_y == 0)
    else $error("invisible point with nonzero coordinates");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("config write refused");

  a_no_stall_idle: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !$past(out_valid) && !$past(in_valid) |-> !in_stall)
    else $error("input stalled while back side drained");

endmodule

bind perspective_point_projector ppp_checker u_chk (.*);
`default_nettype wire
